// ----- design/qpe_pkg.sv -----
package qpe_pkg;

  localparam int T_W     = 24;
  localparam int COEF_W  = 32;
  localparam int RES_W   = 32;
  localparam int FRAC_W  = 16;
  localparam int ORDER   = 5;
  localparam int NCOEF   = ORDER + 1;
  localparam int NCELL   = NCOEF;
  localparam int NLANE   = 3;
  localparam int LIMB_W  = 32;
  localparam int NLIMB   = 5;
  localparam int WIDE_W  = NLIMB * LIMB_W;
  localparam int PROD_W  = LIMB_W + T_W;
  localparam int STAGE_W = 3;
  localparam int DER_W   = 2;
  localparam int DFACT_W = 5;
  localparam int TERM_W  = COEF_W + DFACT_W + 1;

  // lane codes, also the derivative order of each lane
  localparam logic [DER_W-1:0] DER_POS = 2'd0;
  localparam logic [DER_W-1:0] DER_VEL = 2'd1;
  localparam logic [DER_W-1:0] DER_ACC = 2'd2;

  typedef logic [WIDE_W-1:0] wide_t;

  typedef struct packed {
    logic [T_W-1:0]                t;
    logic [NCOEF-1:0][COEF_W-1:0]  coef;
    logic [NLANE-1:0][WIDE_W-1:0]  lane;
  } item_t;

  typedef struct packed {
    logic               ovf;
    logic [RES_W-1:0]   value;
  } sat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] position;
    logic signed [RES_W-1:0] velocity;
    logic signed [RES_W-1:0] acceleration;
    logic                    overflow;
  } result_t;

  // derivative-weighted coefficient, placed at its horner scale
  function automatic wide_t coef_term(input logic [NCOEF-1:0][COEF_W-1:0] coef,
                                      input logic [STAGE_W-1:0] m,
                                      input logic [DER_W-1:0] d);
    logic [DFACT_W-1:0]       f;
    logic signed [TERM_W-1:0] prod;
    wide_t                    term;
    case (d)
      DER_POS: f = DFACT_W'(1);
      DER_VEL: f = DFACT_W'(m);
      DER_ACC: f = DFACT_W'(m) * (DFACT_W'(m) - DFACT_W'(1));
      default: f = '0;
    endcase
    if (int'(m) > ORDER) begin
      term = '0;
    end else begin
      prod = $signed(coef[m]) * $signed({1'b0, f});
      term = WIDE_W'(prod) << (FRAC_W * (ORDER - int'(m)));
    end
    return term;
  endfunction

  // floor to q16.16 and saturate
  function automatic sat_t sat_q16(input wide_t x, input logic [DER_W-1:0] d);
    logic signed [WIDE_W-1:0] s;
    sat_t                     r;
    s = $signed(x) >>> (FRAC_W * (ORDER - int'(d)));
    if (s == {{(WIDE_W-RES_W){s[RES_W-1]}}, s[RES_W-1:0]}) begin
      r.ovf   = 1'b0;
      r.value = s[RES_W-1:0];
    end else begin
      r.ovf   = 1'b1;
      r.value = s[WIDE_W-1] ? {1'b1, {(RES_W-1){1'b0}}} : {1'b0, {(RES_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ----- design/qpe_cell.sv -----
module qpe_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic [qpe_pkg::STAGE_W-1:0]   stage,
  input  logic                          in_valid,
  input  qpe_pkg::item_t                in_item,
  output logic                          out_valid,
  output qpe_pkg::item_t                out_item
);
  import qpe_pkg::*;

  typedef struct packed {
    logic [T_W-1:0]                          t;
    logic [NCOEF-1:0][COEF_W-1:0]            coef;
    logic [NLANE-1:0][NLIMB-1:0][PROD_W-1:0] part;
    logic [NLANE-1:0][WIDE_W-1:0]            addend;
  } mid_t;

  mid_t  mid_r, mid_nxt;
  logic  mid_v_r;
  item_t item_r, item_nxt;
  logic  item_v_r;

  // limb products and coefficient terms
  always_comb begin
    mid_nxt.t    = in_item.t;
    mid_nxt.coef = in_item.coef;
    for (int l = 0; l < NLANE; l++) begin
      mid_nxt.addend[l] = coef_term(in_item.coef, STAGE_W'(stage + STAGE_W'(l)), DER_W'(l));
      for (int k = 0; k < NLIMB; k++) begin
        mid_nxt.part[l][k] = PROD_W'(in_item.lane[l][k*LIMB_W +: LIMB_W]) * PROD_W'(in_item.t);
      end
    end
  end

  // horner step: lane * t + term, modulo the accumulator width
  always_comb begin
    item_nxt.t    = mid_r.t;
    item_nxt.coef = mid_r.coef;
    for (int l = 0; l < NLANE; l++) begin
      item_nxt.lane[l] = mid_r.addend[l];
      for (int k = 0; k < NLIMB; k++) begin
        item_nxt.lane[l] = item_nxt.lane[l] + (WIDE_W'(mid_r.part[l][k]) << (k * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r  <= 1'b0;
      item_v_r <= 1'b0;
    end else if (en) begin
      mid_v_r  <= in_valid;
      item_v_r <= mid_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_r  <= mid_nxt;
      item_r <= item_nxt;
    end
  end

  assign out_valid = item_v_r;
  assign out_item  = item_r;

endmodule

// ----- design/qpe_sat.sv -----
module qpe_sat (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  qpe_pkg::item_t    in_item,
  output logic              out_valid,
  output qpe_pkg::result_t  out_res
);
  import qpe_pkg::*;

  sat_t    pos, vel, acc;
  result_t res_r, res_nxt;
  logic    res_v_r;

  always_comb begin
    pos = sat_q16(in_item.lane[DER_POS], DER_POS);
    vel = sat_q16(in_item.lane[DER_VEL], DER_VEL);
    acc = sat_q16(in_item.lane[DER_ACC], DER_ACC);
    res_nxt.position     = $signed(pos.value);
    res_nxt.velocity     = $signed(vel.value);
    res_nxt.acceleration = $signed(acc.value);
    res_nxt.overflow     = pos.ovf | vel.ovf | acc.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_v_r <= 1'b0;
    end else if (en) begin
      res_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_v_r;
  assign out_res   = res_r;

endmodule

// ----- design/qpe_skid.sv -----
module qpe_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qpe_pkg::result_t  in_res,
  output logic              out_valid,
  input  logic              out_ready,
  output qpe_pkg::result_t  out_res
);
  import qpe_pkg::*;

  result_t out_r, skid_r;
  logic    out_v_r, skid_v_r;
  logic    push;

  assign in_ready = !skid_v_r;
  assign push     = in_valid && !skid_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : in_res;
    end else if (push) begin
      skid_r <= in_res;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

// ----- design/quintic_poly_pos_vel_acc_eval.sv -----
// Evaluates position, velocity and acceleration of a quintic segment at one
// local time (unsigned q8.16) from six signed q16.16 coefficients. Results
// are exact sums floored to q16.16 and saturated, with overflow set when any
// of the three saturated. The block takes one item per clock while out_ready
// is high; each item passes through six horner cells of two register stages
// each (limb multiply, then accumulate), one saturation register and the
// output register. The output register has a skid entry, so in_ready drops
// only when that entry is full.
module quintic_poly_pos_vel_acc_eval (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [qpe_pkg::T_W-1:0]      in_time_q8_16,
  input  logic signed [qpe_pkg::COEF_W-1:0]   in_coef_0,
  input  logic signed [qpe_pkg::COEF_W-1:0]   in_coef_1,
  input  logic signed [qpe_pkg::COEF_W-1:0]   in_coef_2,
  input  logic signed [qpe_pkg::COEF_W-1:0]   in_coef_3,
  input  logic signed [qpe_pkg::COEF_W-1:0]   in_coef_4,
  input  logic signed [qpe_pkg::COEF_W-1:0]   in_coef_5,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [qpe_pkg::RES_W-1:0]    out_position,
  output logic signed [qpe_pkg::RES_W-1:0]    out_velocity,
  output logic signed [qpe_pkg::RES_W-1:0]    out_acceleration,
  output logic                                out_overflow
);
  import qpe_pkg::*;

  logic    en;
  logic    chain_v [NCELL+1];
  item_t   chain_item [NCELL+1];
  logic    sat_v;
  result_t sat_res;
  result_t res;

  always_comb begin
    chain_item[0].t       = in_time_q8_16;
    chain_item[0].coef[0] = in_coef_0;
    chain_item[0].coef[1] = in_coef_1;
    chain_item[0].coef[2] = in_coef_2;
    chain_item[0].coef[3] = in_coef_3;
    chain_item[0].coef[4] = in_coef_4;
    chain_item[0].coef[5] = in_coef_5;
    chain_item[0].lane    = '0;
  end
  assign chain_v[0] = in_valid;

  // cell n handles the coefficient of degree NCELL-1-n for position, one degree higher per derivative lane
  for (genvar n = 0; n < NCELL; n++) begin : g_cell
    qpe_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .stage     (STAGE_W'(NCELL - 1 - n)),
      .in_valid  (chain_v[n]),
      .in_item   (chain_item[n]),
      .out_valid (chain_v[n+1]),
      .out_item  (chain_item[n+1])
    );
  end

  qpe_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (chain_v[NCELL]),
    .in_item   (chain_item[NCELL]),
    .out_valid (sat_v),
    .out_res   (sat_res)
  );

  qpe_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sat_v),
    .in_ready  (en),
    .in_res    (sat_res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign in_ready         = en;
  assign out_position     = res.position;
  assign out_velocity     = res.velocity;
  assign out_acceleration = res.acceleration;
  assign out_overflow     = res.overflow;

endmodule
